// File: src/ray_disk_intersect_checker_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ray / disk intersection checker
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef RAY_DISK_INTERSECT_CHECKER_TOP_ASSERT_SVH
`define RAY_DISK_INTERSECT_CHECKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RDIC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdic: same-cycle check failed");
// next-cycle implication
`define RDIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdic: next-cycle check failed");
`else
`define RDIC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RDIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/rdic_pkg.sv
// ----------------------------------------------------------------------------
// rdic_pkg
// Shared types, widths and constants of the ray / disk intersection checker.
// ----------------------------------------------------------------------------
package rdic_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TILE_UNITS    = 100;
    localparam int CFG_AW        = 5;
    localparam int T_W           = 31;   // ray parameter width
    localparam int NUM_W         = 67;   // numerator dot product, signed
    localparam int DEN_W         = 66;   // denominator dot product, signed
    localparam int RAD_W         = 31;

    typedef enum logic [2:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_RADIUS
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
    } t_ray;

    typedef struct packed {
        logic valid;
        logic miss;
        logic ovf;
    } t_div_ctl;

    // 2^k mod 25
    function automatic int pow2_mod25(input int k);
        int r;
        r = 1;
        for (int i = 0; i < k; i++) begin
            r = r * 2;
            if (r >= 25) begin
                r = r - 25;
            end
        end
        return r;
    endfunction

endpackage

// File: src/ray_disk_intersect_checker_top.sv
// ----------------------------------------------------------------------------
// ray_disk_intersect_checker_top
// Ray against a configured disk in fixed point, with hit point and tile bit.
// ----------------------------------------------------------------------------
// One ray is taken in every clock cycle (busy stays low) and its result comes
// out as a one-cycle o_valid strobe; results leave in the order the rays came
// in and cannot be held off, so the receiver must take every strobe. The path
// runs through the dot-product stages, the divider for the ray parameter,
// which resolves one quotient bit per stage over 31 stages, and the hit-point
// and radius-test stages. A miss gives all result fields zero. Disk registers
// must be written over the APB port only while no ray is in flight; the block
// itself does not enforce this.
module ray_disk_intersect_checker_top #(
    parameter int FRAC_BITS = rdic_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          i_origin_x,
    input  logic signed [31:0]          i_origin_y,
    input  logic signed [31:0]          i_origin_z,
    input  logic signed [31:0]          i_dir_x,
    input  logic signed [31:0]          i_dir_y,
    input  logic signed [31:0]          i_dir_z,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [30:0]                 o_hit_distance,
    output logic signed [31:0]          o_hit_x,
    output logic signed [31:0]          o_hit_y,
    output logic signed [31:0]          o_hit_z,
    output logic                        o_bright_tile,
    output logic                        o_overflow,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rdic_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import rdic_pkg::*;
    `include "ray_disk_intersect_checker_top_assert.svh"

    localparam int P_W   = 65 - FRAC_BITS;          // unclamped hit point
    localparam int E_W   = P_W + 1;                 // hit point minus center
    localparam int MB    = FRAC_BITS + 3;           // floor(coord / 8 units)
    localparam int M_W   = P_W - MB;
    localparam int NGRP  = (M_W + 7) / 8;
    localparam int RES_W = 11;
    localparam int CORR  = (25 - pow2_mod25(M_W)) % 25;

    // ---------------- configuration ----------------
    logic signed [31:0] r_center [3];
    logic signed [31:0] r_normal [3];
    logic [RAD_W-1:0]   r_radius;
    logic [61:0]        r_r2;
    logic               w_cfg_wr;
    t_reg_idx           w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = t_reg_idx'(paddr[CFG_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_normal[0] <= '0;
            r_normal[1] <= 32'(1) << FRAC_BITS;
            r_normal[2] <= '0;
            r_radius    <= RAD_W'(TILE_UNITS) << FRAC_BITS;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_CENTER_X: r_center[0] <= pwdata;
                REG_CENTER_Y: r_center[1] <= pwdata;
                REG_CENTER_Z: r_center[2] <= pwdata;
                REG_NORMAL_X: r_normal[0] <= pwdata;
                REG_NORMAL_Y: r_normal[1] <= pwdata;
                REG_NORMAL_Z: r_normal[2] <= pwdata;
                REG_RADIUS:   r_radius    <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_CENTER_X: prdata = r_center[0];
            REG_CENTER_Y: prdata = r_center[1];
            REG_CENTER_Z: prdata = r_center[2];
            REG_NORMAL_X: prdata = r_normal[0];
            REG_NORMAL_Y: prdata = r_normal[1];
            REG_NORMAL_Z: prdata = r_normal[2];
            REG_RADIUS:   prdata = {1'b0, r_radius};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= 62'(r_radius) * 62'(r_radius);
    end

    // ---------------- intake and dot products ----------------
    logic w_accept;
    t_ray w_in_ray;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_in_ray.o[0] = i_origin_x;
    assign w_in_ray.o[1] = i_origin_y;
    assign w_in_ray.o[2] = i_origin_z;
    assign w_in_ray.d[0] = i_dir_x;
    assign w_in_ray.d[1] = i_dir_y;
    assign w_in_ray.d[2] = i_dir_z;

    logic               r_s1_v;
    t_ray               r_s1_ray;
    logic signed [32:0] r_s1_diff [3];
    logic               r_s2_v;
    t_ray               r_s2_ray;
    logic signed [64:0] r_s2_pn [3];
    logic signed [63:0] r_s2_pd [3];
    logic               r_s3_v;
    t_ray               r_s3_ray;
    logic signed [NUM_W-1:0] r_s3_num;
    logic signed [DEN_W-1:0] r_s3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= w_accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ray <= w_in_ray;
        for (int i = 0; i < 3; i++) begin
            r_s1_diff[i] <= 33'(r_center[i]) - 33'($signed(w_in_ray.o[i]));
        end
        r_s2_ray <= r_s1_ray;
        for (int i = 0; i < 3; i++) begin
            r_s2_pn[i] <= 65'(r_s1_diff[i]) * 65'(r_normal[i]);
            r_s2_pd[i] <= 64'($signed(r_s1_ray.d[i])) * 64'(r_normal[i]);
        end
        r_s3_ray <= r_s2_ray;
        r_s3_num <= NUM_W'(r_s2_pn[0]) + NUM_W'(r_s2_pn[1]) + NUM_W'(r_s2_pn[2]);
        r_s3_den <= DEN_W'(r_s2_pd[0]) + DEN_W'(r_s2_pd[1]) + DEN_W'(r_s2_pd[2]);
    end

    // ---------------- ray parameter ----------------
    t_div_ctl       w_dctl;
    logic [T_W-1:0] w_t;
    t_ray           w_dray;

    rdic_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_v),
        .i_num   (r_s3_num),
        .i_den   (r_s3_den),
        .i_ray   (r_s3_ray),
        .o_ctl   (w_dctl),
        .o_t     (w_t),
        .o_ray   (w_dray)
    );

    // ---------------- hit point, radius test, tile ----------------
    logic                    r_m1_v, r_m1_miss, r_m1_ovf;
    logic [T_W-1:0]          r_m1_t;
    logic [2:0][31:0]        r_m1_o;
    logic signed [63:0]      r_m1_prod [3];

    logic                    r_m2_v, r_m2_miss, r_m2_ovf;
    logic [T_W-1:0]          r_m2_t;
    logic signed [P_W-1:0]   r_m2_p [3];

    logic                    r_m3_v, r_m3_miss, r_m3_ovf;
    logic [T_W-1:0]          r_m3_t;
    logic signed [E_W-1:0]   r_m3_e [3];
    logic [31:0]             r_m3_pos [3];
    logic [7:0]              r_m3_grp [2][NGRP];
    logic                    r_m3_neg [2];
    logic [2:0]              r_m3_lo [2];

    logic                    r_m4_v, r_m4_miss, r_m4_ovf, r_m4_out;
    logic [T_W-1:0]          r_m4_t;
    logic [30:0]             r_m4_ea [3];
    logic [31:0]             r_m4_pos [3];
    logic [RES_W-1:0]        r_m4_tot [2];
    logic [2:0]              r_m4_lo [2];

    logic                    r_m5_v, r_m5_miss, r_m5_ovf, r_m5_out, r_m5_bright;
    logic [T_W-1:0]          r_m5_t;
    logic [61:0]             r_m5_sq [3];
    logic [31:0]             r_m5_pos [3];

    logic                    r_o_valid, r_o_hit, r_o_bright, r_o_ovf;
    logic [T_W-1:0]          r_o_dist;
    logic [31:0]             r_o_pos [3];

    logic signed [P_W-1:0]   w_pxz [2];
    logic [7:0]              w_grp [2][NGRP];
    logic [2:0]              w_clamped;
    logic [31:0]             w_pos [3];
    logic signed [E_W-1:0]   w_rad;
    logic signed [E_W-1:0]   w_eabs [3];
    logic [2:0]              w_out;
    logic [RES_W-1:0]        w_tot [2];
    logic [RES_W-1:0]        w_rem [2];
    logic [7:0]              w_rem200 [2];
    logic [1:0]              w_odd;
    logic [63:0]             w_dist2;
    logic                    w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v    <= 1'b0;
            r_m2_v    <= 1'b0;
            r_m3_v    <= 1'b0;
            r_m4_v    <= 1'b0;
            r_m5_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_m1_v    <= w_dctl.valid;
            r_m2_v    <= r_m1_v;
            r_m3_v    <= r_m2_v;
            r_m4_v    <= r_m3_v;
            r_m5_v    <= r_m4_v;
            r_o_valid <= r_m5_v;
        end
    end

    // clamp to 32 bits, and the per-byte tile residues of x and z
    assign w_pxz[0] = r_m2_p[0];
    assign w_pxz[1] = r_m2_p[2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_clamped[i] = !((r_m2_p[i][P_W-1:31] == '0) || (r_m2_p[i][P_W-1:31] == '1));
            if (!w_clamped[i]) begin
                w_pos[i] = r_m2_p[i][31:0];
            end else if (r_m2_p[i][P_W-1]) begin
                w_pos[i] = 32'h8000_0000;
            end else begin
                w_pos[i] = 32'h7fff_ffff;
            end
        end
        for (int ax = 0; ax < 2; ax++) begin
            for (int g = 0; g < NGRP; g++) begin
                w_grp[ax][g] = '0;
                for (int j = 0; j < 8; j++) begin
                    if ((g * 8 + j) < M_W) begin
                        if (w_pxz[ax][MB + g * 8 + j]) begin
                            w_grp[ax][g] = w_grp[ax][g] + 8'(pow2_mod25(g * 8 + j));
                        end
                    end
                end
            end
        end
    end

    assign w_rad = E_W'($signed({1'b0, r_radius}));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_eabs[i] = r_m3_e[i][E_W-1] ? -r_m3_e[i] : r_m3_e[i];
            w_out[i]  = (r_m3_e[i] > w_rad) || (r_m3_e[i] < -w_rad);
        end
        for (int ax = 0; ax < 2; ax++) begin
            w_tot[ax] = r_m3_neg[ax] ? RES_W'(CORR) : '0;
            for (int g = 0; g < NGRP; g++) begin
                w_tot[ax] = w_tot[ax] + RES_W'(r_m3_grp[ax][g]);
            end
        end
    end

    // reduce mod 25, then place the 3 low bits: remainder of floor(coord) / 200
    always_comb begin
        for (int ax = 0; ax < 2; ax++) begin
            w_rem[ax] = r_m4_tot[ax];
            for (int j = 5; j >= 0; j--) begin
                if (w_rem[ax] >= (RES_W'(25) << j)) begin
                    w_rem[ax] = w_rem[ax] - (RES_W'(25) << j);
                end
            end
            w_rem200[ax] = {w_rem[ax][4:0], r_m4_lo[ax]};
            w_odd[ax]    = w_rem200[ax] >= 8'd100;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_miss <= w_dctl.miss;
        r_m1_ovf  <= w_dctl.ovf;
        r_m1_t    <= w_t;
        r_m1_o    <= w_dray.o;
        for (int i = 0; i < 3; i++) begin
            r_m1_prod[i] <= 64'($signed(w_dray.d[i])) * 64'($signed({1'b0, w_t}));
        end

        r_m2_miss <= r_m1_miss;
        r_m2_ovf  <= r_m1_ovf;
        r_m2_t    <= r_m1_t;
        for (int i = 0; i < 3; i++) begin
            r_m2_p[i] <= P_W'($signed(r_m1_o[i])) + P_W'(r_m1_prod[i] >>> FRAC_BITS);
        end

        r_m3_miss <= r_m2_miss;
        r_m3_ovf  <= r_m2_ovf || (w_clamped != '0);
        r_m3_t    <= r_m2_t;
        for (int i = 0; i < 3; i++) begin
            r_m3_e[i]   <= E_W'(r_m2_p[i]) - E_W'(r_center[i]);
            r_m3_pos[i] <= w_pos[i];
        end
        for (int ax = 0; ax < 2; ax++) begin
            r_m3_grp[ax] <= w_grp[ax];
            r_m3_neg[ax] <= w_pxz[ax][P_W-1];
            r_m3_lo[ax]  <= w_pxz[ax][FRAC_BITS+2:FRAC_BITS];
        end

        r_m4_miss <= r_m3_miss;
        r_m4_ovf  <= r_m3_ovf;
        r_m4_t    <= r_m3_t;
        r_m4_out  <= w_out != '0;
        for (int i = 0; i < 3; i++) begin
            r_m4_ea[i]  <= w_eabs[i][30:0];
            r_m4_pos[i] <= r_m3_pos[i];
        end
        r_m4_tot <= w_tot;
        r_m4_lo  <= r_m3_lo;

        r_m5_miss   <= r_m4_miss;
        r_m5_ovf    <= r_m4_ovf;
        r_m5_t      <= r_m4_t;
        r_m5_out    <= r_m4_out;
        r_m5_bright <= !(w_odd[0] ^ w_odd[1]);
        for (int i = 0; i < 3; i++) begin
            r_m5_sq[i]  <= 62'(r_m4_ea[i]) * 62'(r_m4_ea[i]);
            r_m5_pos[i] <= r_m4_pos[i];
        end
    end

    assign w_dist2 = 64'(r_m5_sq[0]) + 64'(r_m5_sq[1]) + 64'(r_m5_sq[2]);
    assign w_hit   = r_m5_v && !r_m5_miss && !r_m5_out && (w_dist2 <= 64'(r_r2));

    // zero every field unless this is a hit
    always_ff @(posedge i_clk) begin
        r_o_hit    <= w_hit;
        r_o_dist   <= w_hit ? r_m5_t : '0;
        r_o_bright <= w_hit && r_m5_bright;
        r_o_ovf    <= w_hit && r_m5_ovf;
        for (int i = 0; i < 3; i++) begin
            r_o_pos[i] <= w_hit ? r_m5_pos[i] : '0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_hit          = r_o_hit;
    assign o_hit_distance = r_o_dist;
    assign o_hit_x        = r_o_pos[0];
    assign o_hit_y        = r_o_pos[1];
    assign o_hit_z        = r_o_pos[2];
    assign o_bright_tile  = r_o_bright;
    assign o_overflow     = r_o_ovf;

    `RDIC_ASSERT_IMP(a_miss_clears, i_clk, i_rst_n, o_valid && !o_hit, o_hit_distance == '0 && o_hit_x == '0 && o_hit_y == '0 && o_hit_z == '0 && !o_bright_tile && !o_overflow)
    `RDIC_ASSERT_IMP(a_hit_needs_valid, i_clk, i_rst_n, !o_valid, !o_hit)
    `RDIC_ASSERT_IMP(a_hit_nonzero_t, i_clk, i_rst_n, o_valid && o_hit, o_hit_distance != '0)
    `RDIC_ASSERT_NEXT(a_div_t_nonzero, i_clk, i_rst_n, w_dctl.valid && !w_dctl.miss, r_m1_v && r_m1_t != '0)

endmodule

// File: src/rdic_div.sv
// ----------------------------------------------------------------------------
// rdic_div
// Pipelined restoring divider for the ray parameter, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rdic_div #(
    parameter int FRAC_BITS = rdic_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [rdic_pkg::NUM_W-1:0] i_num,
    input  logic signed [rdic_pkg::DEN_W-1:0] i_den,
    input  rdic_pkg::t_ray                    i_ray,
    output rdic_pkg::t_div_ctl                o_ctl,
    output logic [rdic_pkg::T_W-1:0]          o_t,
    output rdic_pkg::t_ray                    o_ray
);
    import rdic_pkg::*;

    localparam int A_W   = NUM_W + FRAC_BITS;
    localparam int CMP_W = A_W + T_W + 1;
    localparam int NSTG  = T_W;

    logic [NUM_W-1:0] w_num_mag;
    logic [DEN_W-1:0] w_den_mag;
    logic             w_miss_in;
    logic             w_ovf;

    logic             r_e_v;
    logic [A_W-1:0]   r_e_a;
    logic [DEN_W-1:0] r_e_b;
    logic             r_e_miss;
    t_ray             r_e_ray;

    logic             r_v    [0:NSTG];
    logic [A_W-1:0]   r_a    [0:NSTG-1];
    logic [DEN_W-1:0] r_b    [0:NSTG-1];
    logic [T_W-1:0]   r_q    [0:NSTG];
    logic             r_ovf  [0:NSTG];
    logic             r_miss [0:NSTG];
    t_ray             r_ray  [0:NSTG];

    assign w_num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_den_mag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
    // parallel ray, zero distance or plane behind the origin
    assign w_miss_in = (i_den == '0) || (i_num == '0) ||
                       (i_num[NUM_W-1] != i_den[DEN_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_a    <= {w_num_mag, {FRAC_BITS{1'b0}}};
        r_e_b    <= w_den_mag;
        r_e_miss <= w_miss_in;
        r_e_ray  <= i_ray;
    end

    // quotient does not fit: saturate
    assign w_ovf = CMP_W'(r_e_a) >= (CMP_W'(r_e_b) << T_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[0]    <= r_e_a;
        r_b[0]    <= r_e_b;
        r_q[0]    <= '0;
        r_ovf[0]  <= w_ovf;
        r_miss[0] <= r_e_miss;
        r_ray[0]  <= r_e_ray;
    end

    for (genvar s = 1; s <= NSTG; s++) begin : g_bit
        localparam int K = NSTG - s;
        logic [CMP_W-1:0] w_bk;
        logic [CMP_W-1:0] w_diff;
        logic             w_take;

        assign w_bk   = CMP_W'(r_b[s-1]) << K;
        assign w_diff = CMP_W'(r_a[s-1]) - w_bk;
        assign w_take = !r_ovf[s-1] && !w_diff[CMP_W-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_q[s]    <= r_q[s-1] | (w_take ? (T_W'(1) << K) : '0);
            r_ovf[s]  <= r_ovf[s-1];
            r_miss[s] <= r_miss[s-1];
            r_ray[s]  <= r_ray[s-1];
        end

        if (s < NSTG) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_a[s] <= w_take ? A_W'(w_diff) : r_a[s-1];
                r_b[s] <= r_b[s-1];
            end
        end
    end

    assign o_ctl.valid = r_v[NSTG];
    assign o_ctl.ovf   = r_ovf[NSTG];
    assign o_ctl.miss  = r_miss[NSTG] || (!r_ovf[NSTG] && (r_q[NSTG] == '0));
    assign o_t         = r_ovf[NSTG] ? '1 : r_q[NSTG];
    assign o_ray       = r_ray[NSTG];

endmodule

// File: tb/ray_disk_intersect_checker_scoreboard.sv
// ----------------------------------------------------------------------------
// ray_disk_intersect_checker_scoreboard
// Watches ray transfers, register writes and result strobes of the ray / disk
// checker, predicts each result in exact fixed point and compares in order.
// ----------------------------------------------------------------------------
module ray_disk_intersect_checker_scoreboard (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic signed [31:0]          i_origin_x,
    input  logic signed [31:0]          i_origin_y,
    input  logic signed [31:0]          i_origin_z,
    input  logic signed [31:0]          i_dir_x,
    input  logic signed [31:0]          i_dir_y,
    input  logic signed [31:0]          i_dir_z,
    input  logic                        o_valid,
    input  logic                        o_hit,
    input  logic [30:0]                 o_hit_distance,
    input  logic signed [31:0]          o_hit_x,
    input  logic signed [31:0]          o_hit_y,
    input  logic signed [31:0]          o_hit_z,
    input  logic                        o_bright_tile,
    input  logic                        o_overflow,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rdic_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          o_fail_count,
    output int                          o_pending
);
    import rdic_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic               hit;
        logic [30:0]        hdist;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               bright;
        logic               ovf;
    } t_hit_rec;

    logic signed [31:0] disk_c [3];
    logic signed [31:0] disk_n [3];
    logic [30:0]        disk_r;
    t_hit_rec           hit_q[$];
    int                 fails;

    assign o_fail_count = fails;

    function automatic logic signed [127:0] floor_div128(input logic signed [127:0] v,
                                                          input logic signed [127:0] d);
        logic signed [127:0] q;
        q = v / d;
        if (v % d != 0 && v < 0) q = q - 1;
        return q;
    endfunction

    function automatic t_hit_rec trace_ray(input logic signed [31:0] org [3],
                                           input logic signed [31:0] dir [3]);
        t_hit_rec            r;
        logic signed [127:0] num, den, an, ad, q, e, d2, p [3], tile, s;
        logic                ovf, outside;
        r = '0;
        num = 0;
        den = 0;
        ovf = 0;
        outside = 0;
        d2 = 0;
        for (int i = 0; i < 3; i++) begin
            num = num + 128'(disk_c[i]) * 128'(disk_n[i]) - 128'(org[i]) * 128'(disk_n[i]);
            den = den + 128'(dir[i]) * 128'(disk_n[i]);
        end
        if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return r;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an <<< FB) / ad;
        if (q >= (128'sd1 <<< 31)) begin
            q = 128'sd2147483647;
            ovf = 1;
        end else if (q == 0) begin
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            p[i] = 128'(org[i]) + ((128'(dir[i]) * q) >>> FB);
            e = p[i] - 128'(disk_c[i]);
            if (e < 0) e = -e;
            if (e > 128'(disk_r)) outside = 1;
            else d2 = d2 + e * e;
        end
        if (outside || d2 > 128'(disk_r) * 128'(disk_r)) return r;
        // tile parity uses the unclamped x and z
        tile = 128'(TILE_UNITS) <<< FB;
        s = floor_div128(p[0], tile) + floor_div128(p[2], tile);
        r.hit   = 1;
        r.hdist = q[30:0];
        for (int i = 0; i < 3; i++) begin
            if (p[i] > 128'sd2147483647) begin
                p[i] = 128'sd2147483647;
                ovf = 1;
            end
            if (p[i] < -128'sd2147483648) begin
                p[i] = -128'sd2147483648;
                ovf = 1;
            end
        end
        r.x = p[0][31:0];
        r.y = p[1][31:0];
        r.z = p[2][31:0];
        r.bright = ~s[0];
        r.ovf    = ovf;
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic signed [31:0] org [3], dir [3];
        t_hit_rec           want, got;
        if (!i_rst_n) begin
            disk_c = '{0, 0, 0};
            disk_n = '{0, 32'sd65536, 0};
            disk_r = 31'd6553600;
            hit_q.delete();
            fails = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_CENTER_X: disk_c[0] = pwdata;
                    REG_CENTER_Y: disk_c[1] = pwdata;
                    REG_CENTER_Z: disk_c[2] = pwdata;
                    REG_NORMAL_X: disk_n[0] = pwdata;
                    REG_NORMAL_Y: disk_n[1] = pwdata;
                    REG_NORMAL_Z: disk_n[2] = pwdata;
                    REG_RADIUS:   disk_r    = pwdata[30:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                org = '{i_origin_x, i_origin_y, i_origin_z};
                dir = '{i_dir_x, i_dir_y, i_dir_z};
                want = trace_ray(org, dir);
                hit_q.push_back(want);
            end
            if (o_valid) begin
                got = '{o_hit, o_hit_distance, o_hit_x, o_hit_y, o_hit_z,
                        o_bright_tile, o_overflow};
                if (hit_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result %h", got);
                end else begin
                    want = hit_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp hit=%0b t=%h p=%h/%h/%h br=%0b ov=%0b",
                                     want.hit, want.hdist, want.x, want.y, want.z,
                                     want.bright, want.ovf,
                                     " got hit=%0b t=%h p=%h/%h/%h br=%0b ov=%0b",
                                     got.hit, got.hdist, got.x, got.y, got.z,
                                     got.bright, got.ovf);
                    end
                end
            end
        end
        o_pending = hit_q.size();
    end
endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Ray / disk checker test: directed rays for each corner case, then random
// rays, most aimed at the disk, under several disk settings and sender gap levels.
// ----------------------------------------------------------------------------
module tb;
    import rdic_pkg::*;

    logic                i_clk, i_rst_n, start, busy;
    logic signed [31:0]  ox, oy, oz, dx, dy, dz;
    logic                o_valid, o_hit, o_bright_tile, o_overflow;
    logic [30:0]         o_hit_distance;
    logic signed [31:0]  o_hit_x, o_hit_y, o_hit_z;
    logic                psel, penable, pwrite, pready;
    logic [CFG_AW-1:0]   paddr;
    logic [31:0]         pwdata, prdata;
    int                  fail_count, pending;
    int                  gap_pct;

    ray_disk_intersect_checker_top dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_origin_x(ox), .i_origin_y(oy), .i_origin_z(oz),
        .i_dir_x(dx), .i_dir_y(dy), .i_dir_z(dz),
        .o_valid, .o_hit, .o_hit_distance, .o_hit_x, .o_hit_y, .o_hit_z,
        .o_bright_tile, .o_overflow,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    ray_disk_intersect_checker_scoreboard scb (
        .i_clk, .i_rst_n, .start, .busy,
        .i_origin_x(ox), .i_origin_y(oy), .i_origin_z(oz),
        .i_dir_x(dx), .i_dir_y(dy), .i_dir_z(dz),
        .o_valid, .o_hit, .o_hit_distance, .o_hit_x, .o_hit_y, .o_hit_z,
        .o_bright_tile, .o_overflow,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= CFG_AW'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic set_disk(input logic [31:0] cx, cy, cz, nx, ny, nz, rad);
        // drain first so no ray sees a half-written disk
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_CENTER_Y, cy);
        reg_write(REG_CENTER_Z, cz);
        reg_write(REG_NORMAL_X, nx);
        reg_write(REG_NORMAL_Y, ny);
        reg_write(REG_NORMAL_Z, nz);
        reg_write(REG_RADIUS, rad);
        @(posedge i_clk);
    endtask

    task automatic send_ray(input logic [31:0] a, b, c, d, e, f);
        while ($urandom_range(99) < gap_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        ox <= a; oy <= b; oz <= c; dx <= d; dy <= e; dz <= f;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // random value: mostly small, sometimes any 32-bit pattern
    function automatic logic [31:0] coord(input int span);
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic random_rays(input int count, input int span);
        logic signed [31:0] tx, tz, sx, sy, sz;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(4) != 0) begin
                // aim from above the plane at a point near the disk
                tx = $urandom_range(2 * span) - span;
                tz = $urandom_range(2 * span) - span;
                sx = $urandom_range(2 * span) - span;
                sy = -($urandom_range(span) + 1);
                sz = $urandom_range(2 * span) - span;
                send_ray(tx - sx, -sy, tz - sz, sx, sy, sz);
            end else begin
                send_ray(coord(span), coord(span), coord(span),
                         coord(span), coord(span), coord(span));
            end
        end
        start <= 0;
    endtask

    initial begin
        start = 0;
        ox = 0; oy = 0; oz = 0; dx = 0; dy = 0; dz = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        gap_pct = 0;
        i_rst_n = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset disk: plane y = 0, radius 100
        send_ray(0, 32'sd655360, 0, 0, -32'sd65536, 0);
        send_ray(32'sd6553600, 32'sd65536, 0, 0, -32'sd65536, 0);
        send_ray(32'sd6553601, 32'sd65536, 0, 0, -32'sd65536, 0);
        send_ray(0, 32'sd65536, 0, 32'sd65536, 0, 0);
        send_ray(0, -32'sd65536, 0, 0, -32'sd65536, 0);
        send_ray(0, 32'sd1, 0, 0, -32'sd2147483648, 0);
        send_ray(0, 32'sd2147483647, 0, 0, -32'sd1, 0);
        send_ray(32'sd3276800, 32'sd65536, -32'sd3276800, 0, -32'sd65536, 0);
        send_ray(-32'sd3276800, 32'sd65536, 32'sd100, 0, -32'sd65536, 0);
        send_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        start <= 0;

        // degenerate normal
        set_disk(0, 0, 0, 0, 0, 0, 32'h7fff_ffff);
        send_ray(0, 32'sd65536, 0, 0, -32'sd65536, 0);
        start <= 0;

        // huge disk far out: clamping and saturation
        set_disk(32'h7fff_0000, 32'h8000_0000, 32'h7fff_0000,
                 32'sd1, 32'sd1, 32'sd1, 32'h7fff_ffff);
        send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, -1, -1, -1);
        send_ray(0, 0, 0, 32'sd1, -32'sd1, 32'sd1);
        send_ray(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        start <= 0;

        set_disk(0, 0, 0, 0, 32'sd65536, 0, 32'sd6553600);
        gap_pct = 0;  random_rays(300, 32'sd13107200);
        gap_pct = 72; random_rays(300, 32'sd13107200);
        set_disk(32'sd3276800, -32'sd655360, 32'sd9830400,
                 32'sd30000, 32'sd50000, -32'sd20000, 32'sd19660800);
        gap_pct = 7;  random_rays(300, 32'sd26214400);
        set_disk(-32'sd1000, 32'sd2000, 32'sd5, 32'sd65536, 0, 0, 0);
        gap_pct = 0;  random_rays(100, 32'sd65536);
        set_disk(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        gap_pct = 72; random_rays(300, 32'sd1000000000);
        set_disk(0, 0, 0, 0, 32'sd65536, 0, 32'sd6553600);
        gap_pct = 30; random_rays(300, 32'sd13107200);

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
